@@ src/bqt_pkg.sv @@
// Package for the binary image quadtree encoder.
// Holds the sizing constants, codes and request/response types; depends on nothing.
`default_nettype none

package bqt_pkg;

    localparam int MAX_SIDE_LOG2 = 6;
    localparam int MAX_SIDE      = 1 << MAX_SIDE_LOG2;
    localparam int PS_DIM        = MAX_SIDE + 1;
    localparam int PS_DEPTH      = PS_DIM * PS_DIM;
    localparam int PS_AW         = $clog2(PS_DEPTH);
    localparam int SUM_W         = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int COORD_W       = MAX_SIDE_LOG2;
    localparam int EXT_W         = COORD_W + 1;
    localparam int LOG_W         = $clog2(MAX_SIDE_LOG2 + 1);
    localparam int POS_W         = 2 * MAX_SIDE_LOG2;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_FETCH  = 1'b1;
    localparam logic STATUS_NODE = 1'b0;
    localparam logic STATUS_NONE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EXEC = 3'b100
    } ctl_state_t;

    typedef enum logic [2:0] {
        PH_WAIT = 3'b001,
        PH_WALK = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

    typedef struct packed {
        logic mode;
        logic pixel_bit;
    } req_t;

    typedef struct packed {
        logic               status;
        logic               is_leaf;
        logic               leaf_value;
        logic [COORD_W-1:0] node_row;
        logic [COORD_W-1:0] node_col;
        logic [LOG_W-1:0]   node_depth;
        logic               last_node;
    } rsp_t;

endpackage

`default_nettype wire

@@ src/binary_image_quadtree_encoder_unit.sv @@
// Binary image quadtree encoder. Depends on bqt_pkg. Pixels of a square image of side
// 2^side_log2 are loaded in row-major order with mode 0 requests, and each one extends a
// 2-D prefix-sum table held in a single synchronous memory of 65 x 65 entries. Once the
// last pixel is in, every mode 1 request returns the next node of the region quadtree in
// preorder (top-left, top-right, bottom-left, bottom-right); a fetch before the load is
// complete or after the last node returns the no-node status. A load request produces no
// response. A load and a fetch that finds a node each go through an accept step, four
// prefix-sum reads in turn through the memory's one read port, and a step that writes
// the new sum or forms the response and steps the walk, before the next request can be
// accepted; a fetch with no node goes from the accept step straight to that last step.
// The first row and column of the table are decoded from the address and never stored,
// so the block needs no clearing pass after reset. A finished response waits in an
// output register, and new requests are taken while it waits; a fetch that finishes
// while that register is still stalled holds in its last step, with the input stalled,
// until the register is taken. Writing side_log2 abandons any load or walk.
`default_nettype none

module binary_image_quadtree_encoder_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  bqt_pkg::req_t              req_data,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output bqt_pkg::rsp_t              rsp_data,
    input  logic                       cfg_we,
    input  logic [bqt_pkg::LOG_W-1:0]  cfg_wdata
);
    import bqt_pkg::*;

    ctl_state_t         state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic [LOG_W-1:0]   side_log2_reg, side_log2_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [COORD_W-1:0] cur_r_reg, cur_r_next;
    logic [COORD_W-1:0] cur_c_reg, cur_c_next;
    logic [LOG_W-1:0]   depth_reg, depth_next;

    logic               op_fetch_reg, op_fetch_next;
    logic               op_none_reg, op_none_next;
    logic [COORD_W-1:0] op_r_reg, op_r_next;
    logic [COORD_W-1:0] op_c_reg, op_c_next;
    logic [LOG_W-1:0]   op_d_reg, op_d_next;
    logic [EXT_W-1:0]   op_len_reg, op_len_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;

    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic [SUM_W-1:0]   ps_mem [PS_DEPTH];
    logic [SUM_W-1:0]   rd_data_reg;
    logic               rd_zero_reg;
    logic               rd_neg_reg;

    logic               rd_en;
    logic [PS_AW-1:0]   rd_addr;
    logic               rd_zero;
    logic [EXT_W-1:0]   rd_row;
    logic [EXT_W-1:0]   rd_col;
    logic               wr_en;
    logic [PS_AW-1:0]   wr_addr;

    logic [LOG_W-1:0]   s_eff;
    logic [EXT_W-1:0]   side;
    logic [EXT_W-1:0]   side_m1;
    logic [EXT_W-1:0]   walk_len;
    logic [POS_W-1:0]   pos_mask;
    logic [SUM_W-1:0]   term;
    logic [SUM_W-1:0]   sum_now;
    logic [SUM_W-1:0]   node_area;
    logic [LOG_W-1:0]   depth_diff;
    logic               leaf;

    logic               up_found;
    logic [LOG_W-1:0]   up_d;
    logic [COORD_W-1:0] up_r;
    logic [COORD_W-1:0] up_c;

    function automatic logic [PS_AW-1:0] ps_addr(input logic [EXT_W-1:0] row,
                                                 input logic [EXT_W-1:0] col);
        ps_addr = (PS_AW'(row) << MAX_SIDE_LOG2) + PS_AW'(row) + PS_AW'(col);
    endfunction

    assign s_eff    = (side_log2_reg > LOG_W'(MAX_SIDE_LOG2)) ? LOG_W'(MAX_SIDE_LOG2)
                                                              : side_log2_reg;
    assign side     = EXT_W'(1) << s_eff;
    assign side_m1  = side - EXT_W'(1);
    assign walk_len = side >> depth_reg;
    assign pos_mask = ~({POS_W{1'b1}} << {s_eff, 1'b0});

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // Four reads: a fetch adds two corners, subtracts two; a load adds two, subtracts one.
    always_comb
    begin
        logic [EXT_W-1:0] row_lo;
        logic [EXT_W-1:0] col_lo;
        logic [EXT_W-1:0] row_hi;
        logic [EXT_W-1:0] col_hi;
        row_lo = {1'b0, op_r_reg};
        col_lo = {1'b0, op_c_reg};
        row_hi = row_lo + op_len_reg;
        col_hi = col_lo + op_len_reg;
        case (cnt_reg)
            2'd0:
            begin
                rd_row = row_hi;
                rd_col = op_fetch_reg ? col_hi : col_lo;
            end
            2'd1:
            begin
                rd_row = row_lo;
                rd_col = op_fetch_reg ? col_lo : col_hi;
            end
            2'd2:
            begin
                rd_row = op_fetch_reg ? row_hi : row_lo;
                rd_col = col_lo;
            end
            default:
            begin
                rd_row = row_lo;
                rd_col = op_fetch_reg ? col_hi : col_lo;
            end
        endcase
        rd_en   = (state_reg == ST_READ);
        rd_addr = ps_addr(rd_row, rd_col);
        rd_zero = (rd_row == '0) || (rd_col == '0) || (!op_fetch_reg && (cnt_reg == 2'd3));
    end

    assign term    = rd_zero_reg ? '0 : rd_data_reg;
    assign sum_now = rd_neg_reg ? (acc_reg - term) : (acc_reg + term);

    assign wr_en   = (state_reg == ST_EXEC) && !op_fetch_reg;
    assign wr_addr = ps_addr({1'b0, op_r_reg} + EXT_W'(1), {1'b0, op_c_reg} + EXT_W'(1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ps_mem[wr_addr] <= sum_now;
        end
        if (rd_en)
        begin
            rd_data_reg <= ps_mem[rd_addr];
            rd_zero_reg <= rd_zero;
            rd_neg_reg  <= cnt_reg[1];
        end
    end

    assign depth_diff = s_eff - op_d_reg;
    assign node_area  = SUM_W'(1) << {depth_diff, 1'b0};
    assign leaf       = (sum_now == '0) || (sum_now == node_area) || (op_d_reg >= s_eff);

    // After a leaf, the walk climbs past every level where it was on the last quadrant,
    // then moves to the next sibling at the first level where it was not.
    always_comb
    begin
        logic [EXT_W-1:0]   half_i;
        logic [EXT_W-1:0]   half_u;
        logic [COORD_W-1:0] hm;
        logic [COORD_W-1:0] base_r;
        logic [COORD_W-1:0] base_c;
        up_found = 1'b0;
        up_d     = '0;
        for (int i = MAX_SIDE_LOG2; i >= 1; i--)
        begin
            half_i = side >> i;
            if (!up_found && (LOG_W'(i) <= op_d_reg)
                && !(((op_r_reg & half_i[COORD_W-1:0]) != '0)
                     && ((op_c_reg & half_i[COORD_W-1:0]) != '0)))
            begin
                up_found = 1'b1;
                up_d     = LOG_W'(i);
            end
        end
        half_u = side >> up_d;
        hm     = half_u[COORD_W-1:0];
        base_r = op_r_reg & ~(hm - COORD_W'(1));
        base_c = op_c_reg & ~(hm - COORD_W'(1));
        if ((base_c & hm) == '0)
        begin
            up_r = base_r;
            up_c = base_c | hm;
        end
        else if ((base_r & hm) == '0)
        begin
            up_r = base_r | hm;
            up_c = base_c & ~hm;
        end
        else
        begin
            up_r = base_r;
            up_c = base_c | hm;
        end
    end

    always_comb
    begin
        logic               restart;
        logic [POS_W-1:0]   eff_pos;
        logic [POS_W-1:0]   load_row;
        state_next     = state_reg;
        phase_next     = phase_reg;
        side_log2_next = side_log2_reg;
        pos_next       = pos_reg;
        cur_r_next     = cur_r_reg;
        cur_c_next     = cur_c_reg;
        depth_next     = depth_reg;
        op_fetch_next  = op_fetch_reg;
        op_none_next   = op_none_reg;
        op_r_next      = op_r_reg;
        op_c_next      = op_c_reg;
        op_d_next      = op_d_reg;
        op_len_next    = op_len_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;

        restart  = (phase_reg != PH_WAIT) || (pos_reg > pos_mask);
        eff_pos  = restart ? '0 : pos_reg;
        load_row = eff_pos >> s_eff;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_fetch_next = (req_data.mode == MODE_FETCH);
                    op_none_next  = 1'b0;
                    cnt_next      = 2'd0;
                    if (req_data.mode == MODE_LOAD)
                    begin
                        op_r_next   = load_row[COORD_W-1:0];
                        op_c_next   = eff_pos[COORD_W-1:0] & side_m1[COORD_W-1:0];
                        op_len_next = EXT_W'(1);
                        acc_next    = SUM_W'(req_data.pixel_bit);
                        pos_next    = eff_pos + POS_W'(1);
                        state_next  = ST_READ;
                        if (eff_pos == pos_mask)
                        begin
                            phase_next = PH_WALK;
                            cur_r_next = '0;
                            cur_c_next = '0;
                            depth_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                        end
                    end
                    else if (phase_reg != PH_WALK)
                    begin
                        op_none_next = 1'b1;
                        state_next   = ST_EXEC;
                    end
                    else
                    begin
                        op_r_next   = cur_r_reg;
                        op_c_next   = cur_c_reg;
                        op_d_next   = depth_reg;
                        op_len_next = walk_len;
                        acc_next    = '0;
                        state_next  = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg != 2'd0)
                begin
                    acc_next = sum_now;
                end
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!op_fetch_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!rsp_valid_reg || !rsp_stall)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    if (op_none_reg)
                    begin
                        rsp_next.status = STATUS_NONE;
                    end
                    else
                    begin
                        rsp_next.status     = STATUS_NODE;
                        rsp_next.is_leaf    = leaf;
                        rsp_next.leaf_value = leaf && (sum_now != '0);
                        rsp_next.node_row   = op_r_reg;
                        rsp_next.node_col   = op_c_reg;
                        rsp_next.node_depth = op_d_reg;
                        rsp_next.last_node  = leaf && !up_found;
                        if (!leaf)
                        begin
                            depth_next = op_d_reg + LOG_W'(1);
                        end
                        else if (up_found)
                        begin
                            depth_next = up_d;
                            cur_r_next = up_r;
                            cur_c_next = up_c;
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            side_log2_next = cfg_wdata;
            phase_next     = PH_WAIT;
            pos_next       = '0;
            depth_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_WAIT;
            side_log2_reg <= LOG_W'(MAX_SIDE_LOG2);
            pos_reg       <= '0;
            depth_reg     <= '0;
            cur_r_reg     <= '0;
            cur_c_reg     <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            side_log2_reg <= side_log2_next;
            pos_reg       <= pos_next;
            depth_reg     <= depth_next;
            cur_r_reg     <= cur_r_next;
            cur_c_reg     <= cur_c_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_fetch_reg <= op_fetch_next;
        op_none_reg  <= op_none_next;
        op_r_reg     <= op_r_next;
        op_c_reg     <= op_c_next;
        op_d_reg     <= op_d_next;
        op_len_reg   <= op_len_next;
        acc_reg      <= acc_next;
        rsp_reg      <= rsp_next;
    end

    // The walk never goes deeper than the single-pixel level of the image in use.
    ap_depth_bound : assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WALK) |-> (depth_reg <= s_eff))
        else $error("walk depth beyond image size");

    // The current node's corner is aligned to its own square size.
    ap_corner_align : assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WALK) |->
            ((({1'b0, cur_r_reg} | {1'b0, cur_c_reg}) & (walk_len - EXT_W'(1))) == '0))
        else $error("node corner not aligned to node size");

    // A new response appears only out of the execute step.
    ap_rsp_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("response raised outside execute step");

endmodule

`default_nettype wire

@@ tb/quadtree_stream_checker.sv @@
// Checker for the binary image quadtree encoder: watches the request, response and
// register ports, predicts the response to every fetch and compares it field by field.
// Depends on bqt_pkg for the payload types, codes and sizing constants.
`timescale 1ns / 100ps

module quadtree_stream_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_stall,
    input  bqt_pkg::req_t             req_data,
    input  logic                      rsp_valid,
    input  logic                      rsp_stall,
    input  bqt_pkg::rsp_t             rsp_data,
    input  logic                      cfg_we,
    input  logic [bqt_pkg::LOG_W-1:0] cfg_wdata,
    output int                        mismatch_count,
    output int                        nodes_pending
);
    import bqt_pkg::*;

    int unsigned      sums [PS_DIM][PS_DIM];
    logic [LOG_W-1:0] side_reg;
    int unsigned      load_pos;
    int unsigned      stk_row [MAX_SIDE_LOG2+1];
    int unsigned      stk_col [MAX_SIDE_LOG2+1];
    int unsigned      depth_now;
    phase_t           phase;
    rsp_t             node_q [$];
    rsp_t             want;
    int               errs;

    function automatic int unsigned side_bits();
        return (side_reg > MAX_SIDE_LOG2) ? MAX_SIDE_LOG2 : side_reg;
    endfunction

    function automatic void apply_pixel(input logic pix);
        int unsigned s, area, r, c;
        s = side_bits();
        area = 1 << (2 * s);
        if (phase != PH_WAIT || load_pos >= area)
        begin
            phase = PH_WAIT;
            load_pos = 0;
        end
        r = load_pos >> s;
        c = load_pos & ((1 << s) - 1);
        sums[r+1][c+1] = sums[r+1][c] + sums[r][c+1] + pix - sums[r][c];
        load_pos++;
        if (load_pos >= area)
        begin
            phase = PH_WALK;
            depth_now = 0;
            stk_row[0] = 0;
            stk_col[0] = 0;
        end
    endfunction

    function automatic rsp_t next_node();
        rsp_t        n;
        int unsigned s, d, r, c, len, total, half;
        logic [1:0]  q;
        bit          leaf, fin;
        n = '0;
        if (phase != PH_WALK)
        begin
            n.status = STATUS_NONE;
            return n;
        end
        s = side_bits();
        d = depth_now;
        r = stk_row[d];
        c = stk_col[d];
        len = (1 << s) >> d;
        total = sums[r+len][c+len] + sums[r][c] - sums[r+len][c] - sums[r][c+len];
        leaf = (total == 0) || (total == len * len) || (d >= s);
        n.status = STATUS_NODE;
        n.is_leaf = leaf;
        n.leaf_value = leaf && (total != 0);
        n.node_row = r[COORD_W-1:0];
        n.node_col = c[COORD_W-1:0];
        n.node_depth = d[LOG_W-1:0];
        if (!leaf)
        begin
            depth_now = d + 1;
            stk_row[d+1] = r;
            stk_col[d+1] = c;
        end
        else
        begin
            // Climb until a square still has a later sibling, or the walk is over.
            fin = 0;
            while (!fin)
            begin
                if (depth_now == 0)
                begin
                    phase = PH_DONE;
                    fin = 1;
                end
                else
                begin
                    d = depth_now;
                    half = (1 << s) >> d;
                    q = {stk_row[d] != stk_row[d-1], stk_col[d] != stk_col[d-1]};
                    if (q == 2'b11)
                        depth_now = d - 1;
                    else
                    begin
                        q = q + 2'b01;
                        stk_row[d] = stk_row[d-1] + (q[1] ? half : 0);
                        stk_col[d] = stk_col[d-1] + (q[0] ? half : 0);
                        fin = 1;
                    end
                end
            end
        end
        n.last_node = (phase == PH_DONE);
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (sums[i, j])
                sums[i][j] = 0;
            foreach (stk_row[i])
            begin
                stk_row[i] = 0;
                stk_col[i] = 0;
            end
            side_reg = LOG_W'(MAX_SIDE_LOG2);
            load_pos = 0;
            depth_now = 0;
            phase = PH_WAIT;
            node_q.delete();
            errs = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                side_reg = cfg_wdata;
                phase = PH_WAIT;
                load_pos = 0;
                depth_now = 0;
            end
            if (req_valid && !req_stall)
            begin
                if (req_data.mode == MODE_FETCH)
                    node_q.push_back(next_node());
                else
                    apply_pixel(req_data.pixel_bit);
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (node_q.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: response with no request waiting", $time);
                end
                else
                begin
                    want = node_q.pop_front();
                    if (rsp_data.status !== want.status || rsp_data.is_leaf !== want.is_leaf
                        || rsp_data.leaf_value !== want.leaf_value
                        || rsp_data.node_row !== want.node_row
                        || rsp_data.node_col !== want.node_col
                        || rsp_data.node_depth !== want.node_depth
                        || rsp_data.last_node !== want.last_node)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            $display("%0t: node mismatch, expected st=%0d leaf=%0d val=%0d",
                                     $time, want.status, want.is_leaf, want.leaf_value,
                                     " row=%0d col=%0d depth=%0d last=%0d",
                                     want.node_row, want.node_col, want.node_depth,
                                     want.last_node);
                            $display("%0t: node mismatch, actual   st=%0d leaf=%0d val=%0d",
                                     $time, rsp_data.status, rsp_data.is_leaf,
                                     rsp_data.leaf_value,
                                     " row=%0d col=%0d depth=%0d last=%0d",
                                     rsp_data.node_row, rsp_data.node_col,
                                     rsp_data.node_depth, rsp_data.last_node);
                        end
                    end
                end
            end
        end
        mismatch_count <= errs;
        nodes_pending <= node_q.size();
    end

endmodule

@@ tb/binary_image_quadtree_encoder_unit_tb.sv @@
// Top of the quadtree encoder testbench: clock, reset, image loads, node fetches,
// register writes and random stalls, with the verdict at the end.
// Depends on bqt_pkg, binary_image_quadtree_encoder_unit and quadtree_stream_checker.
`timescale 1ns / 100ps

module binary_image_quadtree_encoder_unit_tb;
    import bqt_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int SETTLE_CYCLES   = 12;
    localparam int PRESSURE_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 1450;

    localparam int STYLE_ZERO   = 0;
    localparam int STYLE_ONE    = 1;
    localparam int STYLE_NOISE  = 2;
    localparam int STYLE_BLOCKS = 3;
    localparam int STYLE_SPARSE = 4;
    localparam int STYLE_HOLES  = 5;
    localparam int STYLE_DIAG   = 6;
    localparam int STYLE_CORNER = 7;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_stall;
    req_t             req_data = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    rsp_t             rsp_data;
    logic             cfg_we = 1'b0;
    logic [LOG_W-1:0] cfg_wdata = '0;
    int               mismatch_count;
    int               nodes_pending;
    int               last_seen = 0;
    logic             pressure_arm = 1'b0;
    int               items = 0;
    int               burst_left = 0;
    bit               blk [0:63][0:63];

    always #CLK_HALF clk = ~clk;

    binary_image_quadtree_encoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    quadtree_stream_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_data       (req_data),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp_data       (rsp_data),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .nodes_pending  (nodes_pending)
    );

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall && rsp_data.status == STATUS_NODE && rsp_data.last_node)
            last_seen <= last_seen + 1;
    end

    task automatic send_req(input logic mode, input logic pix);
        int   gap;
        req_t r;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 99);
            if (gap < 50)
                gap = 0;
            else if (gap < 85)
                gap = $urandom_range(1, 3);
            else if (gap < 97)
                gap = $urandom_range(4, 10);
            else if (gap < 99)
                gap = $urandom_range(20, 60);
            else
            begin
                gap = 0;
                burst_left = $urandom_range(30, 120);
            end
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r.mode = mode;
        r.pixel_bit = pix;
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items++;
    endtask

    // Register writes wait until every node response is in and a trailing load has settled.
    task automatic set_side(input logic [LOG_W-1:0] v);
        req_valid <= 1'b0;
        @(posedge clk);
        while (nodes_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_image(input int s, input int style, input int count, input bit noisy);
        int   side, g, p, r, c;
        logic pix;
        side = 1 << s;
        g = $urandom_range(0, s);
        for (r = 0; r < side; r++)
            for (c = 0; c < side; c++)
                blk[r][c] = 1'($urandom_range(0, 1));
        for (p = 0; p < count; p++)
        begin
            r = p >> s;
            c = p & (side - 1);
            case (style)
                STYLE_ZERO:   pix = 1'b0;
                STYLE_ONE:    pix = 1'b1;
                STYLE_NOISE:  pix = 1'($urandom_range(0, 1));
                STYLE_BLOCKS: pix = blk[r >> g][c >> g];
                STYLE_SPARSE: pix = ($urandom_range(0, 63) == 0);
                STYLE_HOLES:  pix = ($urandom_range(0, 63) != 0);
                STYLE_DIAG:   pix = (r == c);
                default:      pix = !(r == side - 1 && c == side - 1);
            endcase
            if (noisy && $urandom_range(0, 49) == 0)
                send_req(MODE_FETCH, 1'($urandom_range(0, 1)));
            send_req(MODE_LOAD, pix);
        end
    endtask

    task automatic fetch_stream(input int limit);
        int start, n;
        start = last_seen;
        n = 0;
        while (last_seen == start && n < limit)
        begin
            send_req(MODE_FETCH, 1'($urandom_range(0, 1)));
            n++;
        end
    endtask

    initial
    begin
        int stall_run, free_run, k;
        bit pressure_done;
        stall_run = 0;
        free_run = 0;
        pressure_done = 0;
        forever
        begin
            @(posedge clk);
            if (pressure_arm && !pressure_done)
            begin
                pressure_done = 1;
                stall_run = PRESSURE_CYCLES;
                free_run = 1;
            end
            else if (stall_run == 0 && free_run == 0)
            begin
                k = $urandom_range(0, 99);
                free_run = (k < 10) ? $urandom_range(100, 300) : $urandom_range(1, 8);
                k = $urandom_range(0, 99);
                stall_run = (k < 40) ? 0 : (k < 92) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
            end
            if (stall_run > 0)
            begin
                rsp_stall <= 1'b1;
                stall_run--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                free_run--;
            end
        end
    end

    initial
    begin
        int s, cur_side, pick, area, stop_at, style;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_req(MODE_FETCH, 1'b1);
        set_side(LOG_W'(0));
        send_req(MODE_LOAD, 1'b1);
        send_req(MODE_FETCH, 1'b0);
        send_req(MODE_FETCH, 1'b0);
        send_req(MODE_LOAD, 1'b0);
        send_req(MODE_FETCH, 1'b1);
        set_side(LOG_W'(1));
        send_req(MODE_LOAD, 1'b1);
        send_req(MODE_LOAD, 1'b0);
        send_req(MODE_FETCH, 1'b0);
        send_req(MODE_LOAD, 1'b0);
        send_req(MODE_LOAD, 1'b1);
        repeat (6) send_req(MODE_FETCH, 1'b0);
        send_req(MODE_LOAD, 1'b1);

        // An oversized side acts as the largest one, so a short load leaves the image open.
        set_side(LOG_W'(7));
        load_image(MAX_SIDE_LOG2, STYLE_NOISE, 64, 1'b0);
        send_req(MODE_FETCH, 1'b0);

        set_side(LOG_W'(4));
        load_image(4, STYLE_NOISE, 256, 1'b0);
        pressure_arm <= 1'b1;
        fetch_stream(120);

        cur_side = 4;
        stop_at = items + RANDOM_ITEMS;
        while (items < stop_at)
        begin
            pick = $urandom_range(0, 99);
            s = (pick < 2) ? 5 : $urandom_range(0, 4);
            if (s != cur_side || $urandom_range(0, 3) == 0)
            begin
                set_side(LOG_W'(s));
                cur_side = s;
            end
            area = 1 << (2 * s);
            style = $urandom_range(STYLE_ZERO, STYLE_CORNER);
            pick = $urandom_range(0, 99);
            if (pick < 6)
                repeat ($urandom_range(1, 4)) send_req(MODE_FETCH, 1'($urandom_range(0, 1)));
            else if (pick < 14)
            begin
                // A register write in the middle of a load abandons it.
                load_image(s, style, $urandom_range(0, area - 1), 1'b1);
                set_side(LOG_W'(s));
            end
            else
            begin
                load_image(s, style, area, 1'b1);
                fetch_stream((pick < 24) ? $urandom_range(1, area) : 4 * area + 4);
            end
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (nodes_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
